// File: hdl/cabi_pkg.sv
`default_nettype none
package cabi_pkg;

  localparam int OPC_W   = 2;
  localparam int SOCK_W  = 4;
  localparam int CORE_W  = 6;
  localparam int NODE_W  = 8;
  localparam int CIDX_W  = 10;
  localparam int STS_W   = 2;
  localparam int PN_W    = SOCK_W + CORE_W;

  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPC_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPC_W-1:0] OP_TEST   = 2'd2;
  localparam logic [OPC_W-1:0] OP_SET    = 2'd3;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  localparam logic [CIDX_W-1:0] CIDX_MAX = {CIDX_W{1'b1}};

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [SOCK_W-1:0] node_sockets;
    logic [CORE_W-1:0] socket_cores;
    logic [NODE_W-1:0] node_number;
    logic [SOCK_W-1:0] socket_number;
    logic [CORE_W-1:0] core_number;
  } cabi_cmd_t;

  typedef struct packed {
    logic              bit_value;
    logic [CIDX_W-1:0] core_index;
    logic [STS_W-1:0]  status;
  } cabi_res_t;

endpackage
`default_nettype wire

// File: hdl/cabi_ram.sv
`default_nettype none
module cabi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                             wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: hdl/cabi_mul.sv
`default_nettype none
module cabi_mul #(
  parameter int A_W = 10,
  parameter int B_W = 9
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
  end

endmodule
`default_nettype wire

// File: hdl/core_allocation_bitmap_indexer_top.sv
`default_nettype none
// Core allocation bitmap indexer. Keeps a run-length table of node shapes
// (sockets x cores, with a repeat count per run) and a one-bit-per-core
// allocation bitmap. Commands: clear, append node, test bit, set bit; every
// command returns one result. One command is in work at a time, while the
// previous result may still wait in the output register. All products go
// through one shared registered multiplier and the run table is a
// single-read-port RAM; test and set walk the run table one run at a time
// (up to RUN_SLOTS runs), test then reads the bitmap bit, and clear
// zeroes the bitmap RAM one entry per cycle. The same zeroing pass runs
// after reset, during which no command is taken.
module core_allocation_bitmap_indexer_top
  import cabi_pkg::*;
#(
  parameter int RUN_SLOTS   = 16,
  parameter int BITMAP_BITS = 1024,
  parameter int MAX_NODES   = 256
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire cabi_cmd_t cmd,
  output logic           res_valid,
  input  wire logic      res_ready,
  output cabi_res_t      res
);

  localparam int RUN_AW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int RC_W   = $clog2(RUN_SLOTS + 1);
  localparam int REP_W  = $clog2(MAX_NODES + 1);
  localparam int CT_W   = $clog2(BITMAP_BITS + 1);
  localparam int IDX_W  = $clog2(BITMAP_BITS + 1024);
  localparam int SUM_W  = IDX_W + 1;
  localparam int BM_AW  = $clog2(BITMAP_BITS);
  localparam int MB_W   = (REP_W > NODE_W) ? REP_W : NODE_W;
  localparam int ENT_W  = SOCK_W + CORE_W + REP_W;

  typedef enum logic [11:0] {
    ST_SWEEP   = 12'b0000_0000_0001,
    ST_IDLE    = 12'b0000_0000_0010,
    ST_APP_MUL = 12'b0000_0000_0100,
    ST_APP_UPD = 12'b0000_0000_1000,
    ST_W_DATA  = 12'b0000_0001_0000,
    ST_W_PN    = 12'b0000_0010_0000,
    ST_W_FULL  = 12'b0000_0100_0000,
    ST_W_PART  = 12'b0000_1000_0000,
    ST_W_SOCK  = 12'b0001_0000_0000,
    ST_CHECK   = 12'b0010_0000_0000,
    ST_BIT     = 12'b0100_0000_0000,
    ST_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t             state, state_next;
  logic [BM_AW-1:0]   sweep_addr, sweep_addr_next;
  logic               sweep_reply, sweep_reply_next;
  cabi_cmd_t          cmd_q, cmd_q_next;
  logic [RC_W-1:0]    run_count, run_count_next;
  logic [CT_W-1:0]    core_total, core_total_next;
  logic [REP_W-1:0]   node_total, node_total_next;
  logic [SOCK_W-1:0]  last_sockets, last_sockets_next;
  logic [CORE_W-1:0]  last_cores, last_cores_next;
  logic [REP_W-1:0]   last_rep, last_rep_next;
  logic [RC_W-1:0]    walk, walk_next;
  logic [NODE_W-1:0]  node_left, node_left_next;
  logic [CORE_W-1:0]  cur_cores, cur_cores_next;
  logic [REP_W-1:0]   cur_rep, cur_rep_next;
  logic [IDX_W-1:0]   idx, idx_next;
  cabi_res_t          res_hold, res_hold_next;
  logic               res_valid_next;
  cabi_res_t          res_next;

  logic [PN_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [PN_W+MB_W-1:0] mul_p;

  logic               run_we;
  logic [RUN_AW-1:0]  run_wr_addr;
  logic [ENT_W-1:0]   run_wr_data;
  logic [ENT_W-1:0]   run_rd_data;
  logic [RC_W-1:0]    run_last;

  logic               bm_we;
  logic [BM_AW-1:0]   bm_wr_addr;
  logic               bm_wr_data;
  logic               bm_rd_data;

  logic [PN_W-1:0]    app_add;
  logic [SUM_W-1:0]   app_sum;
  logic               app_same;
  logic               app_fail;
  logic               rep_fits;
  logic               out_of_range;
  logic               rd_fits;

  cabi_mul #(.A_W(PN_W), .B_W(MB_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  cabi_ram #(.WIDTH(ENT_W), .DEPTH(RUN_SLOTS)) u_run_ram (
    .clk     (clk),
    .we      (run_we),
    .wr_addr (run_wr_addr),
    .wr_data (run_wr_data),
    .rd_addr (walk_next[RUN_AW-1:0]),
    .rd_data (run_rd_data)
  );

  cabi_ram #(.WIDTH(1), .DEPTH(BITMAP_BITS)) u_bitmap_ram (
    .clk     (clk),
    .we      (bm_we),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data),
    .rd_addr (idx[BM_AW-1:0]),
    .rd_data (bm_rd_data)
  );

  assign cmd_ready = (state == ST_IDLE);
  assign run_last  = run_count - RC_W'(1);
  assign app_add   = mul_p[PN_W-1:0];
  assign app_sum   = SUM_W'(core_total) + SUM_W'(app_add);
  assign app_same  = (run_count != '0) && (last_sockets == cmd_q.node_sockets) &&
                     (last_cores == cmd_q.socket_cores);
  assign app_fail  = (node_total >= REP_W'(MAX_NODES)) ||
                     (app_sum > SUM_W'(BITMAP_BITS)) ||
                     (!app_same && (run_count >= RC_W'(RUN_SLOTS)));
  assign rep_fits  = MB_W'(cur_rep) <= MB_W'(node_left);
  assign out_of_range = (idx >= IDX_W'(core_total)) || (idx >= IDX_W'(BITMAP_BITS));
  assign rd_fits   = MB_W'(run_rd_data[REP_W-1:0]) <= MB_W'(node_left);

  always_comb begin
    state_next        = state;
    sweep_addr_next   = sweep_addr;
    sweep_reply_next  = sweep_reply;
    cmd_q_next        = cmd_q;
    run_count_next    = run_count;
    core_total_next   = core_total;
    node_total_next   = node_total;
    last_sockets_next = last_sockets;
    last_cores_next   = last_cores;
    last_rep_next     = last_rep;
    walk_next         = walk;
    node_left_next    = node_left;
    cur_cores_next    = cur_cores;
    cur_rep_next      = cur_rep;
    idx_next          = idx;
    res_hold_next     = res_hold;
    res_valid_next    = res_valid;
    res_next          = res;
    mul_a             = '0;
    mul_b             = '0;
    run_we            = 1'b0;
    run_wr_addr       = run_count[RUN_AW-1:0];
    run_wr_data       = '0;
    bm_we             = 1'b0;
    bm_wr_addr        = sweep_addr;
    bm_wr_data        = 1'b0;

    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end

    case (state)
      ST_SWEEP: begin
        bm_we = 1'b1;
        sweep_addr_next = sweep_addr + BM_AW'(1);
        if (sweep_addr == BM_AW'(BITMAP_BITS - 1)) begin
          sweep_addr_next = '0;
          state_next = sweep_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_q_next     = cmd;
          res_hold_next  = '{bit_value: 1'b0, core_index: '0, status: STS_OK};
          walk_next      = '0;
          node_left_next = cmd.node_number;
          idx_next       = '0;
          case (cmd.opcode)
            OP_CLEAR: begin
              run_count_next   = '0;
              core_total_next  = '0;
              node_total_next  = '0;
              sweep_addr_next  = '0;
              sweep_reply_next = 1'b1;
              state_next       = ST_SWEEP;
            end
            OP_APPEND: begin
              state_next = ST_APP_MUL;
            end
            default: begin
              state_next = (run_count == '0) ? ST_CHECK : ST_W_DATA;
            end
          endcase
        end
      end
      ST_APP_MUL: begin
        mul_a = PN_W'(cmd_q.socket_cores);
        mul_b = MB_W'(cmd_q.node_sockets);
        state_next = ST_APP_UPD;
      end
      ST_APP_UPD: begin
        if (app_fail) begin
          res_hold_next.status = STS_FULL;
        end else begin
          run_we = 1'b1;
          last_sockets_next = cmd_q.node_sockets;
          last_cores_next   = cmd_q.socket_cores;
          if (app_same) begin
            run_wr_addr   = run_last[RUN_AW-1:0];
            last_rep_next = last_rep + REP_W'(1);
          end else begin
            run_wr_addr    = run_count[RUN_AW-1:0];
            last_rep_next  = REP_W'(1);
            run_count_next = run_count + RC_W'(1);
          end
          run_wr_data     = {cmd_q.node_sockets, cmd_q.socket_cores, last_rep_next};
          core_total_next = CT_W'(app_sum);
          node_total_next = node_total + REP_W'(1);
        end
        state_next = ST_DONE;
      end
      ST_W_DATA: begin
        cur_rep_next   = run_rd_data[REP_W-1:0];
        cur_cores_next = run_rd_data[REP_W +: CORE_W];
        mul_a = PN_W'(run_rd_data[REP_W +: CORE_W]);
        mul_b = MB_W'(run_rd_data[REP_W+CORE_W +: SOCK_W]);
        state_next = ST_W_PN;
        if (rd_fits) begin
          state_next = ST_W_PN;
        end
      end
      ST_W_PN: begin
        mul_a = mul_p[PN_W-1:0];
        if (rep_fits) begin
          mul_b          = MB_W'(cur_rep);
          node_left_next = node_left - NODE_W'(cur_rep);
          state_next     = ST_W_FULL;
        end else begin
          mul_b      = MB_W'(node_left);
          state_next = ST_W_PART;
        end
      end
      ST_W_FULL: begin
        idx_next  = idx + IDX_W'(mul_p);
        walk_next = walk + RC_W'(1);
        state_next = (walk_next == run_count) ? ST_CHECK : ST_W_DATA;
      end
      ST_W_PART: begin
        idx_next = idx + IDX_W'(mul_p);
        mul_a = PN_W'(cur_cores);
        mul_b = MB_W'(cmd_q.socket_number);
        state_next = ST_W_SOCK;
      end
      ST_W_SOCK: begin
        idx_next = idx + IDX_W'(mul_p) + IDX_W'(cmd_q.core_number);
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        res_hold_next.core_index = (idx > IDX_W'(CIDX_MAX)) ? CIDX_MAX : idx[CIDX_W-1:0];
        if (out_of_range) begin
          res_hold_next.status = STS_RANGE;
          state_next = ST_DONE;
        end else if (cmd_q.opcode == OP_SET) begin
          bm_we      = 1'b1;
          bm_wr_addr = idx[BM_AW-1:0];
          bm_wr_data = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        res_hold_next.bit_value = bm_rd_data;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          res_next         = res_hold;
          res_valid_next   = 1'b1;
          sweep_reply_next = 1'b0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      run_count   <= '0;
      core_total  <= '0;
      node_total  <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      sweep_addr  <= sweep_addr_next;
      sweep_reply <= sweep_reply_next;
      run_count   <= run_count_next;
      core_total  <= core_total_next;
      node_total  <= node_total_next;
      res_valid   <= res_valid_next;
    end
    cmd_q        <= cmd_q_next;
    last_sockets <= last_sockets_next;
    last_cores   <= last_cores_next;
    last_rep     <= last_rep_next;
    walk         <= walk_next;
    node_left    <= node_left_next;
    cur_cores    <= cur_cores_next;
    cur_rep      <= cur_rep_next;
    idx          <= idx_next;
    res_hold     <= res_hold_next;
    res          <= res_next;
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    core_total <= CT_W'(BITMAP_BITS))
    else $error("core total beyond bitmap size");

  a_runs_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= RC_W'(RUN_SLOTS))
    else $error("run count beyond table size");

  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    node_total <= REP_W'(MAX_NODES))
    else $error("node count beyond limit");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_W_FULL) |-> (walk < run_count))
    else $error("run walk past last run");

  a_set_in_range: assert property (@(posedge clk) disable iff (rst)
    (bm_we && (state == ST_CHECK)) |-> (idx < IDX_W'(core_total)))
    else $error("bitmap set outside layout");
`endif

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import cabi_pkg::*;

  localparam int RUN_SLOTS   = 16;
  localparam int BITMAP_BITS = 1024;
  localparam int MAX_NODES   = 256;
  localparam int TOTAL_ITEMS = 1150;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 20000;

  class alloc_layout_checker;
    bit [SOCK_W-1:0] run_socks[RUN_SLOTS];
    bit [CORE_W-1:0] run_cores[RUN_SLOTS];
    int              run_reps[RUN_SLOTS];
    int              run_cnt;
    int              core_total;
    bit              core_bits[BITMAP_BITS];
    cabi_res_t       pending_results[$];
    int              mismatches;

    function new();
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      run_cnt = 0;
      core_total = 0;
      foreach (core_bits[i]) core_bits[i] = 1'b0;
    endfunction

    function int node_total();
      int n;
      n = 0;
      for (int i = 0; i < run_cnt; i++) n += run_reps[i];
      return n;
    endfunction

    function void node_shape(input int node, output int socks, output int cores);
      int left;
      left = node;
      socks = 0;
      cores = 0;
      for (int i = 0; i < run_cnt; i++) begin
        if (left < run_reps[i]) begin
          socks = int'(run_socks[i]);
          cores = int'(run_cores[i]);
          return;
        end
        left -= run_reps[i];
      end
    endfunction

    function cabi_res_t apply_cmd(cabi_cmd_t c);
      cabi_res_t r;
      int        add;
      int        idx;
      int        left;
      bit        same;
      r = '0;
      case (c.opcode)
        OP_CLEAR: wipe();
        OP_APPEND: begin
          add = int'(c.node_sockets) * int'(c.socket_cores);
          same = run_cnt > 0 && run_socks[run_cnt-1] == c.node_sockets &&
                 run_cores[run_cnt-1] == c.socket_cores;
          if (node_total() >= MAX_NODES || core_total + add > BITMAP_BITS ||
              (!same && run_cnt >= RUN_SLOTS)) begin
            r.status = STS_FULL;
          end else begin
            if (!same) begin
              run_socks[run_cnt] = c.node_sockets;
              run_cores[run_cnt] = c.socket_cores;
              run_reps[run_cnt] = 0;
              run_cnt++;
            end
            run_reps[run_cnt-1]++;
            core_total += add;
          end
        end
        default: begin
          idx = 0;
          left = int'(c.node_number);
          for (int i = 0; i < run_cnt; i++) begin
            if (run_reps[i] <= left) begin
              idx += int'(run_socks[i]) * int'(run_cores[i]) * run_reps[i];
              left -= run_reps[i];
            end else begin
              idx += int'(run_socks[i]) * int'(run_cores[i]) * left +
                     int'(run_cores[i]) * int'(c.socket_number) + int'(c.core_number);
              break;
            end
          end
          r.core_index = (idx > int'(CIDX_MAX)) ? CIDX_MAX : idx[CIDX_W-1:0];
          if (idx >= core_total || idx >= BITMAP_BITS) begin
            r.status = STS_RANGE;
          end else if (c.opcode == OP_TEST) begin
            r.bit_value = core_bits[idx];
          end else begin
            core_bits[idx] = 1'b1;
          end
        end
      endcase
      return r;
    endfunction

    function void note_cmd(cabi_cmd_t c);
      pending_results.push_back(apply_cmd(c));
    endfunction

    function void check_res(cabi_res_t got);
      cabi_res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: bit=%0d index=%0d status=%0d",
                   got.bit_value, got.core_index, got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got.bit_value !== want.bit_value || got.core_index !== want.core_index ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected bit=%0d index=%0d status=%0d, ",
                    "got bit=%0d index=%0d status=%0d"},
                   want.bit_value, want.core_index, want.status,
                   got.bit_value, got.core_index, got.status);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  cabi_cmd_t cmd;
  logic      res_valid;
  logic      res_ready;
  cabi_res_t res;

  alloc_layout_checker layout_chk;
  int send_idle;
  int recv_idle;
  bit stall_req;
  int sent;

  core_allocation_bitmap_indexer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic cabi_cmd_t make_cmd(logic [OPC_W-1:0] op, int socks, int cores,
                                         int node, int sock, int core);
    cabi_cmd_t c;
    c.opcode        = op;
    c.node_sockets  = socks[SOCK_W-1:0];
    c.socket_cores  = cores[CORE_W-1:0];
    c.node_number   = node[NODE_W-1:0];
    c.socket_number = sock[SOCK_W-1:0];
    c.core_number   = core[CORE_W-1:0];
    return c;
  endfunction

  // Called and returns just after a falling edge, with nothing driven yet in that step.
  task automatic send_cmd(cabi_cmd_t c);
    while ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    layout_chk.note_cmd(c);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (layout_chk.pending_results.size() != 0) @(negedge clk);
  endtask

  // Test or set; inside the shape of an existing node in in_shape_pct percent of calls.
  task automatic probe(int in_shape_pct);
    int nodes;
    int node;
    int socks;
    int cores;
    logic [OPC_W-1:0] op;
    op = $urandom_range(1) ? OP_TEST : OP_SET;
    nodes = layout_chk.node_total();
    if (nodes > 0 && $urandom_range(99) < in_shape_pct) begin
      node = $urandom_range(nodes - 1);
      layout_chk.node_shape(node, socks, cores);
      send_cmd(make_cmd(op, $urandom, $urandom, node,
                        socks > 0 ? $urandom_range(socks - 1) : 0,
                        cores > 0 ? $urandom_range(cores - 1) : 0));
    end else begin
      node = $urandom_range(1) ? $urandom_range(nodes + 1) : $urandom;
      send_cmd(make_cmd(op, $urandom, $urandom, node, $urandom, $urandom));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_ready === 1'b1) layout_chk.check_res(res);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (stall_req) begin
        res_ready <= 1'b0;
        stall_req = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int pick;
    int k;
    int ps[3];
    int pc[3];
    int sa;
    int ca;
    layout_chk = new();
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    res_ready = 1'b0;
    send_idle = 10;
    recv_idle = 55;
    stall_req = 1'b0;
    sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty layout, exact bitmap fill, saturation, zero-core run, clear
    send_cmd(make_cmd(OP_TEST, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_SET, 15, 63, 255, 15, 63));
    send_cmd(make_cmd(OP_APPEND, 1, 63, 0, 0, 0));
    send_cmd(make_cmd(OP_APPEND, 15, 63, 255, 15, 63));
    send_cmd(make_cmd(OP_APPEND, 1, 16, 0, 0, 0));
    send_cmd(make_cmd(OP_APPEND, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_APPEND, 1, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_TEST, 0, 0, 1, 15, 63));
    send_cmd(make_cmd(OP_SET, 0, 0, 1, 14, 62));
    send_cmd(make_cmd(OP_TEST, 0, 0, 1, 14, 62));
    send_cmd(make_cmd(OP_SET, 0, 0, 2, 0, 15));
    send_cmd(make_cmd(OP_TEST, 0, 0, 2, 0, 15));
    send_cmd(make_cmd(OP_TEST, 0, 0, 3, 0, 5));
    send_cmd(make_cmd(OP_TEST, 0, 0, 200, 0, 0));
    send_cmd(make_cmd(OP_TEST, 0, 0, 0, 1, 0));
    send_cmd(make_cmd(OP_CLEAR, 15, 63, 255, 15, 63));
    send_cmd(make_cmd(OP_TEST, 0, 0, 1, 14, 62));
    send_cmd(make_cmd(OP_APPEND, 2, 4, 0, 0, 0));
    send_cmd(make_cmd(OP_APPEND, 2, 4, 0, 0, 0));
    send_cmd(make_cmd(OP_SET, 0, 0, 1, 1, 3));
    send_cmd(make_cmd(OP_TEST, 0, 0, 0, 3, 7));
    send_cmd(make_cmd(OP_TEST, 0, 0, 0, 3, 3));

    // receiver holds off while commands keep coming, then the sender drains
    stall_req = 1'b1;
    repeat (12) probe(85);
    wait_idle();

    // node limit
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < MAX_NODES + 2; i++)
      send_cmd(make_cmd(OP_APPEND, 1, i < 128 ? 2 : 1, 0, 0, 0));
    repeat (20) probe(85);

    while (sent < TOTAL_ITEMS) begin
      if (sent < TOTAL_ITEMS / 3) begin
        send_idle = 10;
        recv_idle = 55;
      end else if (sent < 2 * TOTAL_ITEMS / 3) begin
        send_idle = 55;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        if ($urandom_range(1))
          send_cmd(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(9) == 0) begin
            ps[i] = $urandom_range(15);
            pc[i] = $urandom_range(63);
          end else begin
            ps[i] = $urandom_range(4);
            pc[i] = $urandom_range(8);
          end
        end
        repeat ($urandom_range(1, 6)) begin
          k = $urandom_range(2);
          send_cmd(make_cmd(OP_APPEND, ps[k], pc[k], $urandom, $urandom, $urandom));
        end
        repeat ($urandom_range(10, 40)) probe(85);
      end else if (pick < 72) begin
        // run table overflow: alternate two shapes
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
        sa = $urandom_range(1, 3);
        ca = $urandom_range(1, 3);
        for (int i = 0; i < RUN_SLOTS + 2; i++)
          send_cmd(make_cmd(OP_APPEND, sa, (i % 2) ? ca : (ca % 3) + 1, 0, 0, 0));
        repeat (15) probe(85);
      end else if (pick < 82) begin
        // bitmap overflow with large nodes
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
        repeat (4) send_cmd(make_cmd(OP_APPEND, $urandom_range(8, 15), $urandom_range(32, 63),
                                     0, 0, 0));
        repeat (15) probe(50);
      end else begin
        repeat ($urandom_range(5, 15))
          send_cmd(make_cmd(OPC_W'($urandom), $urandom, $urandom, $urandom, $urandom,
                            $urandom));
      end
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (layout_chk.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/cabi_pkg.sv
hdl/cabi_ram.sv
hdl/cabi_mul.sv
hdl/core_allocation_bitmap_indexer_top.sv
bench/tb.sv
